// ===== rtl/core/box_ground_distance_gate_assert.svh =====
// assertion macros for the box ground distance gate
// depends on nothing; included by files that carry assertions
`ifndef BOX_GROUND_DISTANCE_GATE_ASSERT_SVH
`define BOX_GROUND_DISTANCE_GATE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BGDG_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bgdg assertion failed");
`define BGDG_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("bgdg assertion failed");
`else
`define BGDG_ASSERT(label, clk, rst, prop)
`define BGDG_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== rtl/core/bgdg_pkg.sv =====
// shared types, codes and homography constants for the box ground distance gate
// depends on nothing
`default_nettype none
package bgdg_pkg;
   localparam int DETECT_SIZE_DEF  = 416;
   localparam int FRAME_WIDTH_DEF  = 640;
   localparam int FRAME_HEIGHT_DEF = 480;

   localparam int EDGE_W   = 9;
   localparam int CLASS_W  = 3;
   localparam int CMD_W    = 3;
   localparam int DIST_W   = 16;
   localparam int LIMIT_W  = 16;
   localparam int QUOT_W   = 16;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;
   localparam int COEF_W   = 34;
   localparam int PIPE_LAT = 8 + QUOT_W;

   localparam int LATERAL_LIMIT = 65;
   localparam int DIST_SCALE    = 100;

   localparam logic signed [COEF_W-1:0] HOM_C0 = -34'sd15812;
   localparam logic signed [COEF_W-1:0] HOM_C1 = -34'sd325486;
   localparam logic signed [COEF_W-1:0] HOM_C2 = -34'sd654112060;
   localparam logic signed [COEF_W-1:0] HOM_C3 = 34'sd3051089;
   localparam logic signed [COEF_W-1:0] HOM_C4 = -34'sd38720;
   localparam logic signed [COEF_W-1:0] HOM_C5 = -34'sd972370464;
   localparam logic signed [COEF_W-1:0] HOM_C6 = -34'sd13990;
   localparam logic signed [COEF_W-1:0] HOM_C7 = -34'sd16584649;
   localparam logic signed [COEF_W-1:0] HOM_C8 = 34'sd4294967296;

   localparam logic [CLASS_W-1:0] CLS_LEFT      = 3'd0;
   localparam logic [CLASS_W-1:0] CLS_RIGHT     = 3'd1;
   localparam logic [CLASS_W-1:0] CLS_STOP      = 3'd2;
   localparam logic [CLASS_W-1:0] CLS_CROSSWALK = 3'd3;
   localparam logic [CLASS_W-1:0] CLS_LIGHT     = 3'd4;

   localparam logic [CMD_W-1:0] CMD_LEFT  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_RIGHT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_STOP  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_RED   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_GREEN = 3'd4;

   localparam logic CSR_NEAR = 1'b0;
   localparam logic CSR_FAR  = 1'b1;

   typedef struct packed {
      logic             valid;
      logic             keep;
      logic [CMD_W-1:0] command;
   } ctl_type;
endpackage
`default_nettype wire

// ===== rtl/core/bgdg_scale.sv =====
// three-stage edge scaling from detector grid to camera frame
// depends on bgdg_pkg
`default_nettype none
module bgdg_scale import bgdg_pkg::*; #(
   parameter int DETECT_SIZE  = DETECT_SIZE_DEF,
   parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
   parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF,
   parameter int SCALE_W      = 10
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ctl_type             in_ctl,
   input  wire logic [EDGE_W-1:0]   in_left,
   input  wire logic [EDGE_W-1:0]   in_right,
   input  wire logic [EDGE_W-1:0]   in_bottom,
   output      ctl_type             out_ctl,
   output      logic [SCALE_W-1:0]  out_left,
   output      logic [SCALE_W-1:0]  out_right,
   output      logic [SCALE_W-1:0]  out_bottom
);
   localparam int FMAX = (FRAME_WIDTH > FRAME_HEIGHT) ? FRAME_WIDTH : FRAME_HEIGHT;
   localparam int PW   = EDGE_W + $clog2(FMAX + 1);
   localparam int SH   = PW + $clog2(DETECT_SIZE);
   localparam int RW   = PW + 1;
   localparam int MW   = 2 * PW + 2;
   localparam logic [RW-1:0] RECIP = RW'((64'd1 << SH) / DETECT_SIZE);

   ctl_type ctl_ff [3];
   logic [EDGE_W-1:0]  edge_val [3];
   logic [SCALE_W-1:0] res      [3];

   assign edge_val[0] = in_left;
   assign edge_val[1] = in_right;
   assign edge_val[2] = in_bottom;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
         ctl_ff[1] <= '0;
         ctl_ff[2] <= '0;
      end else begin
         ctl_ff[0] <= in_ctl;
         ctl_ff[1] <= ctl_ff[0];
         ctl_ff[2] <= ctl_ff[1];
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_lane
      localparam int FR = (i == 2) ? FRAME_HEIGHT : FRAME_WIDTH;
      logic [PW-1:0]      p1_ff, p2_ff;
      logic [SCALE_W-1:0] qe_ff, q_ff;
      logic [MW-1:0]      prod;
      logic [PW-1:0]      p1_in, rem;
      logic [SCALE_W-1:0] qe_in, q_in;

      always_comb begin
         p1_in = PW'(edge_val[i]) * PW'(FR);
         prod  = MW'(p1_ff) * MW'(RECIP);
         qe_in = prod[SH +: SCALE_W];
         rem   = p2_ff - PW'(qe_ff) * PW'(DETECT_SIZE);
         q_in  = qe_ff + SCALE_W'(rem >= PW'(DETECT_SIZE));
      end

      always_ff @(posedge clock) begin
         p1_ff <= p1_in;
         p2_ff <= p1_ff;
         qe_ff <= qe_in;
         q_ff  <= q_in;
      end
      assign res[i] = q_ff;
   end

   assign out_ctl    = ctl_ff[2];
   assign out_left   = res[0];
   assign out_right  = res[1];
   assign out_bottom = res[2];
endmodule
`default_nettype wire

// ===== rtl/core/bgdg_project.sv =====
// three-stage ground homography: products, sums, sign normalisation
// depends on bgdg_pkg
`default_nettype none
module bgdg_project import bgdg_pkg::*; #(
   parameter int SCALE_W = 10,
   parameter int GEO_W   = SCALE_W + COEF_W + 3
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire ctl_type                   in_ctl,
   input  wire logic [SCALE_W-1:0]        in_left,
   input  wire logic [SCALE_W-1:0]        in_right,
   input  wire logic [SCALE_W-1:0]        in_bottom,
   output      ctl_type                   out_ctl,
   output      logic signed [GEO_W-1:0]   out_gx,
   output      logic signed [GEO_W-1:0]   out_gy,
   output      logic signed [GEO_W-1:0]   out_gz
);
   ctl_type ctl4_ff, ctl5_ff, ctl6_ff;
   logic signed [GEO_W-1:0] px0_ff, py0_ff, px1_ff, py1_ff, pz0_ff, pz1_ff;
   logic signed [GEO_W-1:0] gx_ff, gy_ff, gz_ff;
   logic signed [GEO_W-1:0] nx_ff, ny_ff, nz_ff;
   logic [SCALE_W:0]        xsum;
   logic signed [GEO_W-1:0] xe, ye;
   logic                    neg;

   always_comb begin
      xsum = (SCALE_W+1)'(in_left) + (SCALE_W+1)'(in_right);
      xe   = GEO_W'(signed'({1'b0, xsum[SCALE_W:1]}));
      ye   = GEO_W'(signed'({1'b0, in_bottom}));
      neg  = gz_ff[GEO_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl4_ff <= '0;
         ctl5_ff <= '0;
         ctl6_ff <= '0;
      end else begin
         ctl4_ff <= in_ctl;
         ctl5_ff <= ctl4_ff;
         ctl6_ff <= '{valid: ctl5_ff.valid, keep: ctl5_ff.keep && (gz_ff != '0),
                      command: ctl5_ff.command};
      end
   end

   always_ff @(posedge clock) begin
      px0_ff <= xe * GEO_W'(HOM_C0);
      px1_ff <= ye * GEO_W'(HOM_C1);
      py0_ff <= xe * GEO_W'(HOM_C3);
      py1_ff <= ye * GEO_W'(HOM_C4);
      pz0_ff <= xe * GEO_W'(HOM_C6);
      pz1_ff <= ye * GEO_W'(HOM_C7);
      gx_ff  <= px0_ff + px1_ff + GEO_W'(HOM_C2);
      gy_ff  <= py0_ff + py1_ff + GEO_W'(HOM_C5);
      gz_ff  <= pz0_ff + pz1_ff + GEO_W'(HOM_C8);
      nx_ff  <= neg ? -gx_ff : gx_ff;
      ny_ff  <= neg ? -gy_ff : gy_ff;
      nz_ff  <= neg ? -gz_ff : gz_ff;
   end

   assign out_ctl = ctl6_ff;
   assign out_gx  = nx_ff;
   assign out_gy  = ny_ff;
   assign out_gz  = nz_ff;
endmodule
`default_nettype wire

// ===== rtl/core/bgdg_gate.sv =====
// two-stage forward and lateral distance gates by cross-multiplication
// depends on bgdg_pkg
`default_nettype none
module bgdg_gate import bgdg_pkg::*; #(
   parameter int GEO_W = 47
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ctl_type                       in_ctl,
   input  wire logic signed [GEO_W-1:0]       in_gx,
   input  wire logic signed [GEO_W-1:0]       in_gy,
   input  wire logic signed [GEO_W-1:0]       in_gz,
   input  wire logic [LIMIT_W-1:0]            near_limit,
   input  wire logic [LIMIT_W-1:0]            far_limit,
   output      ctl_type                       out_ctl,
   output      logic [GEO_W+QUOT_W-1:0]       out_num,
   output      logic [GEO_W-1:0]              out_den
);
   localparam int NW   = GEO_W + 8;
   localparam int HW   = GEO_W / 2;
   localparam int HIW  = GEO_W - HW;
   localparam int SW   = LIMIT_W + GEO_W;
   localparam int CMPW = SW + 1;
   localparam int DVW  = GEO_W + QUOT_W;

   ctl_type ctl7_ff, ctl8_ff;
   logic signed [NW-1:0]       nx_ff, ny_ff, lat_ff;
   logic [LIMIT_W+HW-1:0]      nlo_ff, flo_ff;
   logic [LIMIT_W+HIW-1:0]     nhi_ff, fhi_ff;
   logic [GEO_W-1:0]           gz_ff, den_ff;
   logic [DVW-1:0]             num_ff;
   logic [GEO_W-1:0]           gzu;
   logic [SW-1:0]              near_s, far_s;
   logic signed [CMPW-1:0]     nx_c;
   logic                       pass;

   always_comb begin
      gzu    = unsigned'(in_gz);
      near_s = (SW'(nhi_ff) << HW) + SW'(nlo_ff);
      far_s  = (SW'(fhi_ff) << HW) + SW'(flo_ff);
      nx_c   = CMPW'(nx_ff);
      pass   = (nx_c > signed'({1'b0, near_s})) && (nx_c < signed'({1'b0, far_s}))
               && !(ny_ff < -lat_ff) && !(ny_ff > lat_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl7_ff <= '0;
         ctl8_ff <= '0;
      end else begin
         ctl7_ff <= in_ctl;
         ctl8_ff <= '{valid: ctl7_ff.valid, keep: ctl7_ff.keep && pass,
                      command: ctl7_ff.command};
      end
   end

   always_ff @(posedge clock) begin
      nx_ff  <= NW'(in_gx) * NW'(DIST_SCALE);
      ny_ff  <= NW'(in_gy) * NW'(DIST_SCALE);
      lat_ff <= NW'(in_gz) * NW'(LATERAL_LIMIT);
      nlo_ff <= (LIMIT_W+HW)'(near_limit) * (LIMIT_W+HW)'(gzu[HW-1:0]);
      flo_ff <= (LIMIT_W+HW)'(far_limit) * (LIMIT_W+HW)'(gzu[HW-1:0]);
      nhi_ff <= (LIMIT_W+HIW)'(near_limit) * (LIMIT_W+HIW)'(gzu[GEO_W-1:HW]);
      fhi_ff <= (LIMIT_W+HIW)'(far_limit) * (LIMIT_W+HIW)'(gzu[GEO_W-1:HW]);
      gz_ff  <= gzu;
      num_ff <= pass ? DVW'(unsigned'(nx_ff)) : '0;
      den_ff <= gz_ff;
   end

   assign out_ctl = ctl8_ff;
   assign out_num = num_ff;
   assign out_den = den_ff;
endmodule
`default_nettype wire

// ===== rtl/core/bgdg_divide.sv =====
// restoring divider, one quotient bit per register stage
// depends on bgdg_pkg
`default_nettype none
module bgdg_divide import bgdg_pkg::*; #(
   parameter int GEO_W = 47
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire ctl_type                   in_ctl,
   input  wire logic [GEO_W+QUOT_W-1:0]   in_num,
   input  wire logic [GEO_W-1:0]          in_den,
   output      ctl_type                   out_ctl,
   output      logic [QUOT_W-1:0]         out_quot
);
   localparam int DVW = GEO_W + QUOT_W;

   ctl_type           ctl_ff [QUOT_W];
   logic [DVW-1:0]    rem_ff [QUOT_W];
   logic [GEO_W-1:0]  den_ff [QUOT_W];
   logic [QUOT_W-1:0] q_ff   [QUOT_W];

   for (genvar k = 0; k < QUOT_W; k++) begin : g_step
      localparam int B = QUOT_W - 1 - k;
      ctl_type           ctl_src;
      logic [DVW-1:0]    rem_src, sub;
      logic [GEO_W-1:0]  den_src;
      logic [QUOT_W-1:0] q_src;
      logic              ge;

      if (k == 0) begin : g_first
         assign ctl_src = in_ctl;
         assign rem_src = in_num;
         assign den_src = in_den;
         assign q_src   = '0;
      end else begin : g_next
         assign ctl_src = ctl_ff[k-1];
         assign rem_src = rem_ff[k-1];
         assign den_src = den_ff[k-1];
         assign q_src   = q_ff[k-1];
      end

      always_comb begin
         sub = DVW'(den_src) << B;
         ge  = rem_src >= sub;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k] <= '0;
         end else begin
            ctl_ff[k] <= ctl_src;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= ge ? rem_src - sub : rem_src;
         den_ff[k] <= den_src;
         q_ff[k]   <= q_src | (QUOT_W'(ge) << B);
      end
   end

   assign out_ctl  = ctl_ff[QUOT_W-1];
   assign out_quot = q_ff[QUOT_W-1];
endmodule
`default_nettype wire

// ===== rtl/core/box_ground_distance_gate.sv =====
// box ground distance gate: one box accepted every cycle (busy only during reset);
// the 16-stage divider sets the depth; 3 scale, 3 projection, 2 gate stages;
// synchronous reset clears the pipeline control flags and sets near limit 0,
// far limit 300; the receiver cannot stall, results last one cycle
// depends on bgdg_pkg, bgdg_scale, bgdg_project, bgdg_gate, bgdg_divide
`default_nettype none
`include "box_ground_distance_gate_assert.svh"
module box_ground_distance_gate import bgdg_pkg::*; #(
   parameter int DETECT_SIZE  = DETECT_SIZE_DEF,
   parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
   parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output      logic                     busy,
   input  wire logic [CLASS_W-1:0]       req_object_class,
   input  wire logic [EDGE_W-1:0]        req_box_left,
   input  wire logic [EDGE_W-1:0]        req_box_right,
   input  wire logic [EDGE_W-1:0]        req_box_bottom,
   input  wire logic                     req_red_light,
   output      logic                     rsp_strobe,
   output      logic [CMD_W-1:0]         rsp_command,
   output      logic signed [DIST_W-1:0] rsp_distance_cm,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_AW-1:0]        paddr,
   input  wire logic [CSR_DW-1:0]        pwdata,
   output      logic [CSR_DW-1:0]        prdata,
   output      logic                     pready
);
   localparam int FMAX    = (FRAME_WIDTH > FRAME_HEIGHT) ? FRAME_WIDTH : FRAME_HEIGHT;
   localparam int SCALE_W = $clog2(((2**EDGE_W - 1) * FMAX) / DETECT_SIZE + 1);
   localparam int GEO_W   = SCALE_W + COEF_W + 3;

   logic [LIMIT_W-1:0] near_limit_ff, far_limit_ff;
   ctl_type in_ctl, s_ctl, p_ctl, g_ctl, d_ctl;
   logic [SCALE_W-1:0] s_left, s_right, s_bottom;
   logic signed [GEO_W-1:0] p_gx, p_gy, p_gz;
   logic [GEO_W+QUOT_W-1:0] g_num;
   logic [GEO_W-1:0]        g_den;
   logic [QUOT_W-1:0]       d_quot;
   logic                    csr_wr;

   // config registers
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;
   assign prdata = (paddr[2] == CSR_FAR) ? CSR_DW'(far_limit_ff) : CSR_DW'(near_limit_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         near_limit_ff <= '0;
         far_limit_ff  <= LIMIT_W'(300);
      end else if (csr_wr) begin
         if (paddr[2] == CSR_NEAR) begin
            near_limit_ff <= pwdata[LIMIT_W-1:0];
         end else begin
            far_limit_ff <= pwdata[LIMIT_W-1:0];
         end
      end
   end

   // class to command
   assign busy = reset;
   always_comb begin
      in_ctl.valid   = start && !busy;
      in_ctl.keep    = 1'b1;
      in_ctl.command = CMD_LEFT;
      case (req_object_class)
         CLS_LEFT:      in_ctl.command = CMD_LEFT;
         CLS_RIGHT:     in_ctl.command = CMD_RIGHT;
         CLS_STOP:      in_ctl.command = CMD_STOP;
         CLS_CROSSWALK: in_ctl.command = CMD_STOP;
         CLS_LIGHT:     in_ctl.command = req_red_light ? CMD_RED : CMD_GREEN;
         default:       in_ctl.keep    = 1'b0;
      endcase
   end

   bgdg_scale #(
      .DETECT_SIZE(DETECT_SIZE), .FRAME_WIDTH(FRAME_WIDTH),
      .FRAME_HEIGHT(FRAME_HEIGHT), .SCALE_W(SCALE_W)
   ) u_scale (
      .clock(clock), .reset(reset), .in_ctl(in_ctl),
      .in_left(req_box_left), .in_right(req_box_right), .in_bottom(req_box_bottom),
      .out_ctl(s_ctl), .out_left(s_left), .out_right(s_right), .out_bottom(s_bottom)
   );

   bgdg_project #(.SCALE_W(SCALE_W), .GEO_W(GEO_W)) u_project (
      .clock(clock), .reset(reset), .in_ctl(s_ctl),
      .in_left(s_left), .in_right(s_right), .in_bottom(s_bottom),
      .out_ctl(p_ctl), .out_gx(p_gx), .out_gy(p_gy), .out_gz(p_gz)
   );

   bgdg_gate #(.GEO_W(GEO_W)) u_gate (
      .clock(clock), .reset(reset), .in_ctl(p_ctl),
      .in_gx(p_gx), .in_gy(p_gy), .in_gz(p_gz),
      .near_limit(near_limit_ff), .far_limit(far_limit_ff),
      .out_ctl(g_ctl), .out_num(g_num), .out_den(g_den)
   );

   bgdg_divide #(.GEO_W(GEO_W)) u_divide (
      .clock(clock), .reset(reset), .in_ctl(g_ctl),
      .in_num(g_num), .in_den(g_den),
      .out_ctl(d_ctl), .out_quot(d_quot)
   );

   // saturate the word's distance
   assign rsp_strobe      = d_ctl.valid && d_ctl.keep;
   assign rsp_command     = d_ctl.command;
   assign rsp_distance_cm = d_quot[QUOT_W-1] ? signed'(DIST_W'(32767))
                                             : signed'(DIST_W'(d_quot));

   `BGDG_ASSERT(a_cmd_range, clock, reset, rsp_strobe |-> (rsp_command <= CMD_GREEN))
   `BGDG_ASSERT(a_dist_pos, clock, reset, rsp_strobe |-> !rsp_distance_cm[DIST_W-1])
   `BGDG_ASSERT(a_latency, clock, reset, rsp_strobe |-> $past(start && !busy, PIPE_LAT))
   `BGDG_ASSERT(a_near_wr, clock, reset, (csr_wr && paddr[2] == CSR_NEAR) |=> (near_limit_ff == $past(pwdata[LIMIT_W-1:0])))
endmodule
`default_nettype wire
